>>> hdl/dcbr_pkg.sv
// ----------------------------------------------------------------------------
// dcbr_pkg: shared types and constants of the dual-copy bitmap byte resolver
// Holds the item types, the register set, the queue entry and helpers.
// ----------------------------------------------------------------------------
package dcbr_pkg;

  // Word index wide enough for every address the resolver can form.
  localparam int WIX_W = 16;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_LEVEL0_BASE = 3'd0,
    REG_LVL1_OFFSET = 3'd1,
    REG_LVL1_SIZE   = 3'd2,
    REG_LVL2_OFFSET = 3'd3,
    REG_LVL2_SIZE   = 3'd4,
    REG_LVL1_SHIFT  = 3'd5,
    REG_LVL2_SHIFT  = 3'd6,
    REG_DATA_WORDS  = 3'd7
  } reg_idx_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic        req_type;
    logic [13:0] word_addr;
    logic [31:0] word_data;
    logic [15:0] byte_index;
  } req_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       out_of_range;
  } rsp_t;

  typedef struct packed {
    logic [15:0] level0_base;
    logic [15:0] lvl1_offset;
    logic [15:0] lvl1_size;
    logic [15:0] lvl2_offset;
    logic [15:0] lvl2_size;
    logic [4:0]  lvl1_shift;
    logic [4:0]  lvl2_shift;
    logic [14:0] data_words;
  } cfg_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic             is_write;
    logic             wr_ok;      // write address lies inside the memory
    logic [13:0]      word_addr;
    logic [31:0]      word_data;
    logic [15:0]      byte_index;
    logic [15:0]      l2_bit;     // level-2 bit index
    logic [4:0]       l1_pos;     // level-1 bit position within its word
    logic [WIX_W-1:0] w1;         // word holding the level-1 bit
    logic             w1_ok;
  } job_t;

  // A word is usable when it is below the loaded count and inside the memory.
  function automatic logic word_ok(input logic [WIX_W-1:0] w,
                                   input logic [14:0] dw,
                                   input int unsigned mw);
    return (w < {1'b0, dw}) && (32'(w) < mw);
  endfunction

endpackage

>>> hdl/dual_copy_bitmap_byte_resolver.sv
// ----------------------------------------------------------------------------
// dual_copy_bitmap_byte_resolver: two-level copy-select byte lookup
// Loads a partition image word by word and resolves byte reads through it.
// ----------------------------------------------------------------------------
// A write item (req_type 0) stores word_data at word_addr of the image memory
// and returns no result; addresses outside the memory are dropped. A read
// item (req_type 1) returns one result: the byte_index is shifted by
// lvl2_shift to form a level-2 bit index, which is divided by 8 and shifted
// by lvl1_shift to form a level-1 bit index. That bit of the level-1 bitmap
// at level0_base (MSB-first in each word) selects one of two level-2 bitmap
// copies, whose bit selects one of two data copies, and the addressed byte of
// that copy is returned (bytes little-endian in a word). When any of the
// three words lies at or beyond data_words or beyond the memory, the walk
// stops and the result is byte 0 with out_of_range set. Items pass through a
// classifier and a two-entry queue into a sequencer that owns the single
// port of the image memory. A write makes one access to that port, and
// writes run at one item per clock while no read is in the sequencer. A read
// makes three dependent accesses to the same port, in the issue step and the
// L2 and L3 states; its result is registered in the final step, and the next
// item is taken only when that result enters the output register. A read that
// fails its first bound check goes straight to the final step. The input stays
// open while a result waits at the output, until the queue is full.
// Configuration registers sit at byte addresses 4*i on the cfg_ port and
// must only be written while the block holds no pending work. The image
// memory content is undefined until written; no clearing pass is made.
// ----------------------------------------------------------------------------
module dual_copy_bitmap_byte_resolver #(
  parameter int unsigned MEM_WORDS = 16384
) (
  input  logic           clk,
  input  logic           rst_n,

  input  logic           in_valid,
  output logic           in_ready,
  input  dcbr_pkg::req_t in_data,

  output logic           out_valid,
  input  logic           out_ready,
  output dcbr_pkg::rsp_t out_data,

  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [4:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready
);

  localparam int AW = $clog2(MEM_WORDS);

  dcbr_pkg::cfg_t     cfg_r;
  dcbr_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  dcbr_pkg::job_t     front_job;
  dcbr_pkg::job_t     q_job;
  logic               q_valid;
  logic               q_pop;

  logic               ram_en;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [31:0]        ram_wdata;
  logic [31:0]        ram_rdata;

  // Register file: a write lands on the access phase of the transfer.
  assign cfg_pready = 1'b1;
  assign reg_idx    = dcbr_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dcbr_pkg::REG_LEVEL0_BASE: cfg_r.level0_base <= cfg_pwdata[15:0];
        dcbr_pkg::REG_LVL1_OFFSET: cfg_r.lvl1_offset <= cfg_pwdata[15:0];
        dcbr_pkg::REG_LVL1_SIZE:   cfg_r.lvl1_size   <= cfg_pwdata[15:0];
        dcbr_pkg::REG_LVL2_OFFSET: cfg_r.lvl2_offset <= cfg_pwdata[15:0];
        dcbr_pkg::REG_LVL2_SIZE:   cfg_r.lvl2_size   <= cfg_pwdata[15:0];
        dcbr_pkg::REG_LVL1_SHIFT:  cfg_r.lvl1_shift  <= cfg_pwdata[4:0];
        dcbr_pkg::REG_LVL2_SHIFT:  cfg_r.lvl2_shift  <= cfg_pwdata[4:0];
        dcbr_pkg::REG_DATA_WORDS:  cfg_r.data_words  <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dcbr_pkg::REG_LEVEL0_BASE: cfg_prdata = 32'(cfg_r.level0_base);
      dcbr_pkg::REG_LVL1_OFFSET: cfg_prdata = 32'(cfg_r.lvl1_offset);
      dcbr_pkg::REG_LVL1_SIZE:   cfg_prdata = 32'(cfg_r.lvl1_size);
      dcbr_pkg::REG_LVL2_OFFSET: cfg_prdata = 32'(cfg_r.lvl2_offset);
      dcbr_pkg::REG_LVL2_SIZE:   cfg_prdata = 32'(cfg_r.lvl2_size);
      dcbr_pkg::REG_LVL1_SHIFT:  cfg_prdata = 32'(cfg_r.lvl1_shift);
      dcbr_pkg::REG_LVL2_SHIFT:  cfg_prdata = 32'(cfg_r.lvl2_shift);
      dcbr_pkg::REG_DATA_WORDS:  cfg_prdata = 32'(cfg_r.data_words);
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  // Front: classify each item and compute its first bitmap word.
  dcbr_front #(
    .MEM_WORDS(MEM_WORDS)
  ) u_front (
    .cfg (cfg_r),
    .req (in_data),
    .job (front_job)
  );

  // Queue: the input is open whenever it has a free entry.
  dcbr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_job   (front_job),
    .push_ready (in_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_job    (q_job)
  );

  // Back: the sequencer that owns the memory port and the output register.
  dcbr_back #(
    .MEM_WORDS(MEM_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .ram_en    (ram_en),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  dcbr_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_image (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

>>> hdl/dcbr_ram.sv
// ----------------------------------------------------------------------------
// dcbr_ram: generic single-port RAM
// One access per cycle, write or read, with the read data registered.
// ----------------------------------------------------------------------------
module dcbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/dcbr_front.sv
// ----------------------------------------------------------------------------
// dcbr_front: item classifier
// Splits writes from reads and works out the bit indexes and first word.
// ----------------------------------------------------------------------------
module dcbr_front #(
  parameter int unsigned MEM_WORDS = 16384
) (
  input  dcbr_pkg::cfg_t cfg,
  input  dcbr_pkg::req_t req,
  output dcbr_pkg::job_t job
);

  logic [15:0]                l2_bit;
  logic [12:0]                l1_bit;
  logic [dcbr_pkg::WIX_W-1:0] w1;

  assign l2_bit = req.byte_index >> cfg.lvl2_shift;
  assign l1_bit = l2_bit[15:3] >> cfg.lvl1_shift;
  assign w1     = dcbr_pkg::WIX_W'(cfg.level0_base[15:2]) + dcbr_pkg::WIX_W'(l1_bit[12:5]);

  always_comb begin
    job            = '0;
    job.is_write   = (req.req_type == dcbr_pkg::REQ_WRITE);
    job.wr_ok      = (32'(req.word_addr) < MEM_WORDS);
    job.word_addr  = req.word_addr;
    job.word_data  = req.word_data;
    job.byte_index = req.byte_index;
    job.l2_bit     = l2_bit;
    job.l1_pos     = l1_bit[4:0];
    job.w1         = w1;
    job.w1_ok      = dcbr_pkg::word_ok(w1, cfg.data_words, MEM_WORDS);
  end

endmodule

>>> hdl/dcbr_fifo.sv
// ----------------------------------------------------------------------------
// dcbr_fifo: short queue between the front and back parts
// Holds classified items so that either side can stall on its own.
// ----------------------------------------------------------------------------
module dcbr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dcbr_pkg::job_t push_job,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output dcbr_pkg::job_t pop_job
);

  localparam int AW = dcbr_pkg::QAW;

  dcbr_pkg::job_t q_r [dcbr_pkg::QDEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [AW:0]    cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != (AW+1)'(dcbr_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = q_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(dcbr_pkg::QDEPTH))
    else $error("queue count beyond its depth");

endmodule

>>> hdl/dcbr_back.sv
// ----------------------------------------------------------------------------
// dcbr_back: access sequencer
// Walks each read through the level-1 bitmap, level-2 bitmap and data word.
// ----------------------------------------------------------------------------
module dcbr_back #(
  parameter int unsigned MEM_WORDS = 16384
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dcbr_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  input  dcbr_pkg::job_t               q_job,
  output logic                         q_pop,
  output logic                         ram_en,
  output logic                         ram_we,
  output logic [$clog2(MEM_WORDS)-1:0] ram_addr,
  output logic [31:0]                  ram_wdata,
  input  logic [31:0]                  ram_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dcbr_pkg::rsp_t               out_data
);

  localparam int AW = $clog2(MEM_WORDS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_L2,
    ST_L3,
    ST_BYTE
  } state_t;

  state_t         state_r,    state_nxt;
  logic [15:0]    l2_bit_r,   l2_bit_nxt;
  logic [4:0]     l1_pos_r,   l1_pos_nxt;
  logic [15:0]    bidx_r,     bidx_nxt;
  logic           err_r,      err_nxt;
  logic [1:0]     lane_r,     lane_nxt;
  logic           out_valid_r, out_valid_nxt;
  dcbr_pkg::rsp_t out_data_r, out_data_nxt;

  logic                       out_free;
  logic                       sel2;
  logic                       sel3;
  logic [16:0]                addr2;
  logic [17:0]                addr3;
  logic [dcbr_pkg::WIX_W-1:0] w2;
  logic [dcbr_pkg::WIX_W-1:0] w3;
  logic                       ok2;
  logic                       ok3;

  assign out_free = !out_valid_r || out_ready;

  // Level-1 bit picks the level-2 bitmap copy.
  assign sel2  = ram_rdata[~l1_pos_r];
  assign addr2 = {1'b0, cfg.lvl1_offset} + (sel2 ? {1'b0, cfg.lvl1_size} : 17'd0);
  assign w2    = dcbr_pkg::WIX_W'(addr2[16:2]) + dcbr_pkg::WIX_W'(l2_bit_r[15:5]);
  assign ok2   = dcbr_pkg::word_ok(w2, cfg.data_words, MEM_WORDS);

  // Level-2 bit picks the data copy.
  assign sel3  = ram_rdata[~l2_bit_r[4:0]];
  assign addr3 = 18'(cfg.lvl2_offset) + (sel3 ? 18'(cfg.lvl2_size) : 18'd0) + 18'(bidx_r);
  assign w3    = addr3[17:2];
  assign ok3   = dcbr_pkg::word_ok(w3, cfg.data_words, MEM_WORDS);

  always_comb begin
    logic issue;
    issue         = 1'b0;
    state_nxt     = state_r;
    l2_bit_nxt    = l2_bit_r;
    l1_pos_nxt    = l1_pos_r;
    bidx_nxt      = bidx_r;
    err_nxt       = err_r;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = '0;
    ram_wdata     = q_job.word_data;

    unique case (state_r)
      ST_IDLE: begin
        issue = 1'b1;
      end
      ST_L2: begin
        if (ok2) begin
          ram_en    = 1'b1;
          ram_addr  = AW'(w2);
          state_nxt = ST_L3;
        end else begin
          err_nxt   = 1'b1;
          state_nxt = ST_BYTE;
        end
      end
      ST_L3: begin
        lane_nxt  = addr3[1:0];
        state_nxt = ST_BYTE;
        if (ok3) begin
          ram_en   = 1'b1;
          ram_addr = AW'(w3);
        end else begin
          err_nxt = 1'b1;
        end
      end
      ST_BYTE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.out_of_range = err_r;
          out_data_nxt.data_byte    = err_r ? 8'd0 : ram_rdata[{lane_r, 3'b000} +: 8];
          state_nxt                 = ST_IDLE;
          issue                     = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (issue && q_valid) begin
      q_pop = 1'b1;
      if (q_job.is_write) begin
        ram_en    = q_job.wr_ok;
        ram_we    = 1'b1;
        ram_addr  = AW'(q_job.word_addr);
        state_nxt = ST_IDLE;
      end else begin
        l2_bit_nxt = q_job.l2_bit;
        l1_pos_nxt = q_job.l1_pos;
        bidx_nxt   = q_job.byte_index;
        err_nxt    = !q_job.w1_ok;
        lane_nxt   = 2'd0;
        ram_en     = q_job.w1_ok;
        ram_addr   = AW'(q_job.w1);
        state_nxt  = q_job.w1_ok ? ST_L2 : ST_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
    end
    l2_bit_r   <= l2_bit_nxt;
    l1_pos_r   <= l1_pos_nxt;
    bidx_r     <= bidx_nxt;
    lane_r     <= lane_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_write_only_between_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_en && ram_we) |-> (state_r == ST_IDLE || state_r == ST_BYTE))
    else $error("image write issued in the middle of a read walk");

  a_result_from_final_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_BYTE))
    else $error("result raised outside the final step");

  a_l2_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_L2) |=> (state_r == ST_L3 || state_r == ST_BYTE))
    else $error("level-2 step did not advance");

  a_error_carries_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_of_range) |-> (out_data_r.data_byte == 8'd0))
    else $error("out-of-range result with nonzero byte");

endmodule

>>> dv/dual_copy_bitmap_byte_resolver_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_copy_bitmap_byte_resolver_checker: result predictor and comparator
// Watches the item channels and the register port, keeps its own image and
// register copies, predicts each byte lookup and compares it with the block.
// ----------------------------------------------------------------------------
module dual_copy_bitmap_byte_resolver_checker #(
  parameter int unsigned MEM_WORDS = 16384
) (
  input  logic           clk,
  input  logic           rst_n,

  input  logic           in_valid,
  input  logic           in_ready,
  input  dcbr_pkg::req_t in_data,

  input  logic           out_valid,
  input  logic           out_ready,
  input  dcbr_pkg::rsp_t out_data,

  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [4:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  input  logic           cfg_pready,

  output int             fail_count,
  output int             pending
);

  dcbr_pkg::cfg_t layout;
  bit [31:0]      image [MEM_WORDS];
  dcbr_pkg::rsp_t expected_bytes [$];
  int             errors = 0;

  // A word may be fetched only below the loaded count and inside the memory.
  function automatic bit word_loaded(input int unsigned w);
    return (w < layout.data_words) && (w < MEM_WORDS);
  endfunction

  // Walks both bitmap levels for one byte index and returns the result.
  function automatic dcbr_pkg::rsp_t resolve_byte(input logic [15:0] idx);
    int unsigned    l2_bit;
    int unsigned    l1_bit;
    int unsigned    w;
    int unsigned    addr;
    bit             sel;
    dcbr_pkg::rsp_t r;
    r.data_byte    = 8'h00;
    r.out_of_range = 1'b1;
    l2_bit = 32'(idx) >> layout.lvl2_shift;
    l1_bit = (l2_bit / 8) >> layout.lvl1_shift;

    w = 32'(layout.level0_base) / 4 + l1_bit / 32;
    if (!word_loaded(w)) return r;
    sel = image[w][31 - (l1_bit % 32)];

    w = (32'(layout.lvl1_offset) + (sel ? 32'(layout.lvl1_size) : 32'd0)) / 4 + l2_bit / 32;
    if (!word_loaded(w)) return r;
    sel = image[w][31 - (l2_bit % 32)];

    addr = 32'(layout.lvl2_offset) + (sel ? 32'(layout.lvl2_size) : 32'd0) + 32'(idx);
    w    = addr / 4;
    if (!word_loaded(w)) return r;
    r.data_byte    = image[w][8 * (addr % 4) +: 8];
    r.out_of_range = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    dcbr_pkg::rsp_t want;
    if (!rst_n) begin
      layout = '0;
      expected_bytes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          dcbr_pkg::REG_LEVEL0_BASE: layout.level0_base = cfg_pwdata[15:0];
          dcbr_pkg::REG_LVL1_OFFSET: layout.lvl1_offset = cfg_pwdata[15:0];
          dcbr_pkg::REG_LVL1_SIZE:   layout.lvl1_size   = cfg_pwdata[15:0];
          dcbr_pkg::REG_LVL2_OFFSET: layout.lvl2_offset = cfg_pwdata[15:0];
          dcbr_pkg::REG_LVL2_SIZE:   layout.lvl2_size   = cfg_pwdata[15:0];
          dcbr_pkg::REG_LVL1_SHIFT:  layout.lvl1_shift  = cfg_pwdata[4:0];
          dcbr_pkg::REG_LVL2_SHIFT:  layout.lvl2_shift  = cfg_pwdata[4:0];
          dcbr_pkg::REG_DATA_WORDS:  layout.data_words  = cfg_pwdata[14:0];
          default: ;
        endcase
      end

      // The new item is queued before the result is taken, so order holds.
      if (in_valid && in_ready) begin
        if (in_data.req_type == dcbr_pkg::REQ_READ)
          expected_bytes.push_back(resolve_byte(in_data.byte_index));
        else if (in_data.word_addr < MEM_WORDS)
          image[in_data.word_addr] = in_data.word_data;
      end

      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with nothing expected: byte %02h oor %0b",
                     $realtime, out_data.data_byte, out_data.out_of_range);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.data_byte !== want.data_byte ||
              out_data.out_of_range !== want.out_of_range) begin
            if (errors < 10)
              $display("%0t: mismatch: expected byte %02h oor %0b, got byte %02h oor %0b",
                       $realtime, want.data_byte, want.out_of_range,
                       out_data.data_byte, out_data.out_of_range);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_bytes.size();
  end

endmodule

>>> dv/dual_copy_bitmap_byte_resolver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_copy_bitmap_byte_resolver_tb: stimulus and verdict for the resolver
// Loads image words, programs layouts and sends byte lookups under varied
// flow control; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module dual_copy_bitmap_byte_resolver_tb;

  localparam int unsigned IMAGE_WORDS = 16384;
  // Cycles to let the block go quiet after the last result before touching
  // registers; a trailing write item may still hold the memory port.
  localparam int SETTLE_CYCLES = 24;
  // Cycles without any accepted item before the run is declared hung.
  localparam int QUIET_LIMIT   = 2000;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  dcbr_pkg::req_t in_data;
  logic           out_valid;
  logic           out_ready;
  dcbr_pkg::rsp_t out_data;
  logic           cfg_psel;
  logic           cfg_penable;
  logic           cfg_pwrite;
  logic [4:0]     cfg_paddr;
  logic [31:0]    cfg_pwdata;
  logic [31:0]    cfg_prdata;
  logic           cfg_pready;

  int fail_count;
  int pending;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Marks image words that have been written, so that a layout is only used
  // once every word it can reach below the loaded count holds real data.
  bit img_loaded [IMAGE_WORDS];

  dual_copy_bitmap_byte_resolver #(
    .MEM_WORDS (IMAGE_WORDS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dual_copy_bitmap_byte_resolver_checker #(
    .MEM_WORDS (IMAGE_WORDS)
  ) resolver_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The result side stalls at random with the rate of the current phase.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hang detection: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("dual_copy_bitmap_byte_resolver_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write: a setup phase, then an access phase that completes
  // when pready is seen. The select is left high so that writes can follow
  // each other directly; the caller closes the transfer.
  task automatic write_reg(input dcbr_pkg::reg_idx_t r, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Programs every register of a layout; only called while the block is idle.
  task automatic apply_layout(input dcbr_pkg::cfg_t c);
    write_reg(dcbr_pkg::REG_LEVEL0_BASE, 32'(c.level0_base));
    write_reg(dcbr_pkg::REG_LVL1_OFFSET, 32'(c.lvl1_offset));
    write_reg(dcbr_pkg::REG_LVL1_SIZE,   32'(c.lvl1_size));
    write_reg(dcbr_pkg::REG_LVL2_OFFSET, 32'(c.lvl2_offset));
    write_reg(dcbr_pkg::REG_LVL2_SIZE,   32'(c.lvl2_size));
    write_reg(dcbr_pkg::REG_LVL1_SHIFT,  32'(c.lvl1_shift));
    write_reg(dcbr_pkg::REG_LVL2_SHIFT,  32'(c.lvl2_shift));
    write_reg(dcbr_pkg::REG_DATA_WORDS,  32'(c.data_words));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Presents one item and returns at the edge where it is accepted. Valid is
  // left high so that the next item follows without a gap unless the sender
  // decides to idle, dropping valid while it does.
  task automatic issue_item(input dcbr_pkg::req_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.req_type == dcbr_pkg::REQ_WRITE) img_loaded[it.word_addr] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write items carry a random byte index and read items a random address and
  // word, so that the fields a request ignores still see every bit pattern.
  task automatic store_word(input logic [13:0] addr, input logic [31:0] data);
    dcbr_pkg::req_t it;
    it.req_type   = dcbr_pkg::REQ_WRITE;
    it.word_addr  = addr;
    it.word_data  = data;
    it.byte_index = 16'($urandom);
    issue_item(it);
  endtask

  task automatic lookup_byte(input logic [15:0] idx);
    dcbr_pkg::req_t it;
    it.req_type   = dcbr_pkg::REQ_READ;
    it.word_addr  = 14'($urandom);
    it.word_data  = $urandom;
    it.byte_index = idx;
    issue_item(it);
  endtask

  // Writes random data to every word below the count that is still blank.
  task automatic fill_image(input int unsigned words);
    for (int unsigned w = 0; w < words; w++)
      if (!img_loaded[w]) store_word(14'(w), $urandom);
  endtask

  // A quarter of the random items rewrite image words, half of them inside
  // the loaded area so that bitmap bits change under the lookups. Lookups
  // mostly stay near the start of the image, where the walk gets through all
  // three levels; the rest use the whole byte index range.
  task automatic random_item(input int unsigned span_words);
    if ($urandom_range(99) < 25) begin
      if ($urandom_range(1) == 1)
        store_word(14'($urandom_range(span_words - 1)), $urandom);
      else
        store_word(14'($urandom_range(IMAGE_WORDS - 1)), $urandom);
    end else begin
      if ($urandom_range(9) < 7)
        lookup_byte(16'($urandom_range(4 * span_words - 1)));
      else
        lookup_byte(16'($urandom_range(16'hFFFF)));
    end
  endtask

  // Drops valid, waits for every outstanding result and lets the block settle.
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    dcbr_pkg::cfg_t layout;
    int unsigned    words;
    int unsigned    fill_words;
    int unsigned    span;
    int unsigned    n_items;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The layout puts the level-1 bitmap at word 0, the two
    // level-2 copies at words 8 and 16 and the two data copies at words 32
    // and 48, with 64 words loaded.
    layout = '{level0_base: 16'd0,   lvl1_offset: 16'd32, lvl1_size: 16'd32,
               lvl2_offset: 16'd128, lvl2_size:   16'd64, lvl1_shift: 5'd0,
               lvl2_shift:  5'd0,    data_words:  15'd64};
    apply_layout(layout);
    fill_image(64);
    // Level-1 bits all clear, level-2 copy 0 all set: lookups land in data
    // copy 1, one per byte lane of the word.
    store_word(14'd0, 32'h0000_0000);
    store_word(14'd8, 32'hFFFF_FFFF);
    lookup_byte(16'd0);
    lookup_byte(16'd1);
    lookup_byte(16'd2);
    lookup_byte(16'd3);
    // Flip the level-1 bitmap to the second level-2 copy, which picks copy 0.
    store_word(14'd0, 32'hFFFF_FFFF);
    store_word(14'd16, 32'h0000_0000);
    lookup_byte(16'd0);
    // Out of range at the level-1 fetch, at the level-2 fetch, at the data.
    lookup_byte(16'hFFFF);
    lookup_byte(16'd2047);
    lookup_byte(16'd1023);
    // A word at the very top of the memory, outside the loaded count.
    store_word(14'h3FFF, 32'hA5A5_5A5A);
    lookup_byte(16'h8000);
    lookup_byte(16'h7FFF);
    lookup_byte(16'd255);
    lookup_byte(16'd256);
    lookup_byte(16'd100);
    finish_phase();

    // Random part: one layout per phase, the flow control pattern rotating
    // through no idling, sender gaps, receiver stalls and both together.
    for (int p = 0; p < 12; p++) begin
      words              = $urandom_range(16, 256);
      layout.data_words  = 15'(words);
      layout.level0_base = 16'($urandom_range(2 * words));
      layout.lvl1_offset = 16'($urandom_range(2 * words));
      layout.lvl1_size   = 16'($urandom_range(2 * words));
      layout.lvl2_offset = 16'($urandom_range(2 * words));
      layout.lvl2_size   = 16'($urandom_range(2 * words));
      layout.lvl1_shift  = ($urandom_range(9) < 6) ? 5'($urandom_range(3))
                                                   : 5'($urandom_range(31));
      layout.lvl2_shift  = ($urandom_range(9) < 6) ? 5'($urandom_range(3))
                                                   : 5'($urandom_range(31));
      fill_words = words;
      span       = words / 2;
      n_items    = 70;
      case (p)
        0: begin
          // All registers at zero apart from the count: both copies of
          // each level coincide and no shift is applied.
          layout            = '0;
          layout.data_words = 15'd256;
          fill_words        = 256;
          span              = 128;
        end
        6: begin
          // Every register but the count at its top value: the level-1 fetch always
          // falls outside the loaded words.
          layout = '{level0_base: 16'hFFFF, lvl1_offset: 16'hFFFF,
                     lvl1_size:   16'hFFFF, lvl2_offset: 16'hFFFF,
                     lvl2_size:   16'hFFFF, lvl1_shift:  5'd31,
                     lvl2_shift:  5'd31,    data_words:  15'd256};
          fill_words = 256;
          span       = 64;
          n_items    = 40;
        end
        7, 8: begin
          // A loaded count at or past the memory size. The large level-2
          // shift keeps both bitmap fetches on words 0 and 1, while the
          // data copies start in the last word, so almost every lookup
          // runs off the end of the memory; the first has the count past
          // the memory itself.
          layout.data_words  = (p == 7) ? 15'h7FFF : 15'(IMAGE_WORDS);
          layout.level0_base = 16'd0;
          layout.lvl1_offset = 16'd0;
          layout.lvl1_size   = 16'd4;
          layout.lvl2_offset = 16'hFFFC;
          layout.lvl2_size   = 16'($urandom_range(4, 16'hFFFF));
          layout.lvl1_shift  = 5'($urandom_range(31));
          layout.lvl2_shift  = 5'($urandom_range(16, 31));
          fill_words         = 0;
          span               = 4;
          n_items            = 80;
        end
        9: begin
          // Nothing loaded: every lookup fails at its first fetch.
          layout.data_words = 15'd0;
          fill_words        = 0;
          span              = 64;
          n_items           = 40;
        end
        default: ;
      endcase

      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase

      apply_layout(layout);
      fill_image(fill_words);
      if (p == 7 || p == 8) store_word(14'(IMAGE_WORDS - 1), $urandom);
      repeat (n_items) random_item(span);
      finish_phase();
    end

    if (fail_count == 0 && pending == 0)
      $display("dual_copy_bitmap_byte_resolver_tb: clean");
    else
      $display("dual_copy_bitmap_byte_resolver_tb: errors");
    $finish;
  end

endmodule
